// ===== rtl/sgtin_pkg.sv =====
package sgtin_pkg;

    localparam logic [7:0]  HEADER      = 8'h30;
    localparam int          REM_W       = 47;
    localparam int          REF_BITS    = 44;
    localparam int          SPLIT_BITS  = 26;
    localparam int          SERIAL_BITS = 38;
    localparam logic [3:0]  LEN_MIN     = 4'd6;
    localparam logic [3:0]  LEN_MAX     = 4'd12;
    localparam logic [2:0]  PART_BAD    = 3'd7;
    localparam logic [46:0] GTIN_MOD    = 47'd100000000000000;

    typedef struct packed {
        logic        kind;
        logic        bad;
        logic [2:0]  part;
        logic [2:0]  filter;
        logic [46:0] rem;
        logic [39:0] pfx;
        logic [23:0] itm;
        logic [37:0] serial;
        logic [95:0] epc;
    } pipe_t;

    function automatic logic [63:0] pow10(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < n; i++)
        begin
            p = p * 64'd10;
        end
        return p;
    endfunction

    // company prefix field width by partition
    function automatic logic [5:0] prefix_bits(input logic [2:0] part);
        logic [5:0] b;
        unique case (part)
            3'd0:    b = 6'd40;
            3'd1:    b = 6'd37;
            3'd2:    b = 6'd34;
            3'd3:    b = 6'd30;
            3'd4:    b = 6'd27;
            3'd5:    b = 6'd24;
            3'd6:    b = 6'd20;
            default: b = 6'd20;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/sgtin_item_if.sv =====
interface sgtin_item_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [46:0] gtin_number;
    logic [37:0] serial_in;
    logic [31:0] epc_upper;
    logic [63:0] epc_lower;

    modport source (output valid, kind, gtin_number, serial_in, epc_upper, epc_lower,
                    input ready);
    modport sink   (input valid, kind, gtin_number, serial_in, epc_upper, epc_lower,
                    output ready);
endinterface

// ===== rtl/sgtin_result_if.sv =====
interface sgtin_result_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [31:0] tag_upper;
    logic [63:0] tag_lower;
    logic [2:0]  filter_out;
    logic [2:0]  partition_out;
    logic [39:0] prefix_out;
    logic [23:0] item_ref_out;
    logic [37:0] serial_out;

    modport source (output valid, status, tag_upper, tag_lower, filter_out,
                    partition_out, prefix_out, item_ref_out, serial_out,
                    input ready);
    modport sink   (input valid, status, tag_upper, tag_lower, filter_out,
                    partition_out, prefix_out, item_ref_out, serial_out,
                    output ready);
endinterface

// ===== rtl/sgtin96_encode_decode.sv =====
// SGTIN-96 encoder and decoder, one beat in and one beat out per item.
// Channel item: kind 0 encodes gtin_number and serial_in into a 96-bit tag,
// kind 1 decodes epc_upper/epc_lower into filter, partition, prefix, item
// reference and serial. Channel result carries status and all fields; the
// fields of the other direction are zero, and an error zeroes everything.
// Configuration: cfg_we with cfg_index 0 writes prefix_length, index 1 writes
// filter_code; write only while no beat is in flight.
// Pipeline: a front stage folds the GTIN to fourteen digits, then the GTIN is
// split one decimal digit per stage (thirteen digit stages), and the output
// register holds the result beat.
// Throughput: one beat per cycle while no result beat waits with result.ready low.
// Reset: all stage valid bits clear, prefix_length returns to 7 and
// filter_code to 0.
// Stall: while a result beat waits with result.ready low, the whole pipeline
// holds and item.ready drops; nothing is lost or repeated.
module sgtin96_encode_decode (
    input  logic         clk,
    input  logic         rst_n,
    sgtin_item_if.sink   item,
    sgtin_result_if.source result,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [3:0]   cfg_data
);
    import sgtin_pkg::*;

    localparam int NSTG = 13;

    typedef enum logic [0:0] {
        REG_PREFIX_LENGTH = 1'b0,
        REG_FILTER_CODE   = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic        status;
        logic [31:0] tag_upper;
        logic [63:0] tag_lower;
        logic [2:0]  filter_out;
        logic [2:0]  partition_out;
        logic [39:0] prefix_out;
        logic [23:0] item_ref_out;
        logic [37:0] serial_out;
    } res_t;

    logic [3:0] prefix_length_reg;
    logic [2:0] filter_code_reg;
    logic       out_v_reg;
    res_t       res_reg, res_next;
    logic       adv;

    logic       stg_v [0:NSTG];
    pipe_t      stg_d [0:NSTG];

    // hold every stage while the output beat is not taken
    assign adv        = !out_v_reg || result.ready;
    assign item.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_length_reg <= 4'd7;
            filter_code_reg   <= 3'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_PREFIX_LENGTH: prefix_length_reg <= cfg_data;
                REG_FILTER_CODE:   filter_code_reg   <= cfg_data[2:0];
                default:           ;
            endcase
        end
    end

    sgtin_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .in_v          (item.valid),
        .kind          (item.kind),
        .gtin_number   (item.gtin_number),
        .serial_in     (item.serial_in),
        .epc_upper     (item.epc_upper),
        .epc_lower     (item.epc_lower),
        .prefix_length (prefix_length_reg),
        .filter_code   (filter_code_reg),
        .out_v         (stg_v[0]),
        .out_d         (stg_d[0])
    );

    // digit stages: indicator first, then body digits high to low
    for (genvar n = 0; n < NSTG; n++)
    begin : g_digit
        sgtin_digit_stage #(
            .POS (NSTG - n)
        ) u_digit (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .in_v  (stg_v[n]),
            .in_d  (stg_d[n]),
            .out_v (stg_v[n + 1]),
            .out_d (stg_d[n + 1])
        );
    end

    // assemble the result from the last stage
    always_comb
    begin
        logic [57:0] hi_enc;
        logic [57:0] hi_dec;
        logic [5:0]  pb_enc;
        logic [5:0]  pb_dec;
        logic [5:0]  rb_enc;
        logic [5:0]  rb_dec;
        logic [2:0]  part_dec;
        pipe_t       p;

        p        = stg_d[NSTG];
        res_next = '0;
        pb_enc   = prefix_bits(p.part);
        rb_enc   = 6'(REF_BITS) - pb_enc;
        hi_enc   = (58'(HEADER) << 50) | (58'(p.filter) << 47) | (58'(p.part) << 44)
                 | ((58'(p.pfx) & ((58'd1 << pb_enc) - 58'd1)) << rb_enc)
                 | (58'(p.itm) & ((58'd1 << rb_enc) - 58'd1));

        hi_dec   = {p.epc[95:64], p.epc[63:SERIAL_BITS]};
        part_dec = hi_dec[46:44];
        pb_dec   = prefix_bits(part_dec);
        rb_dec   = 6'(REF_BITS) - pb_dec;

        if (!p.kind)
        begin
            if (p.bad)
            begin
                res_next.status = 1'b1;
            end
            else
            begin
                res_next.tag_upper = hi_enc[57:SPLIT_BITS];
                res_next.tag_lower = {hi_enc[SPLIT_BITS-1:0], p.serial};
            end
        end
        else
        begin
            if (part_dec == PART_BAD)
            begin
                res_next.status = 1'b1;
            end
            else
            begin
                res_next.filter_out    = hi_dec[49:47];
                res_next.partition_out = part_dec;
                res_next.prefix_out    = 40'((hi_dec >> rb_dec)
                                              & ((58'd1 << pb_dec) - 58'd1));
                res_next.item_ref_out  = 24'(hi_dec & ((58'd1 << rb_dec) - 58'd1));
                res_next.serial_out    = p.epc[SERIAL_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_v_reg <= stg_v[NSTG];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid         = out_v_reg;
    assign result.status        = res_reg.status;
    assign result.tag_upper     = res_reg.tag_upper;
    assign result.tag_lower     = res_reg.tag_lower;
    assign result.filter_out    = res_reg.filter_out;
    assign result.partition_out = res_reg.partition_out;
    assign result.prefix_out    = res_reg.prefix_out;
    assign result.item_ref_out  = res_reg.item_ref_out;
    assign result.serial_out    = res_reg.serial_out;
endmodule

// ===== rtl/sgtin_front.sv =====
module sgtin_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_v,
    input  logic               kind,
    input  logic [46:0]        gtin_number,
    input  logic [37:0]        serial_in,
    input  logic [31:0]        epc_upper,
    input  logic [63:0]        epc_lower,
    input  logic [3:0]         prefix_length,
    input  logic [2:0]         filter_code,
    output logic               out_v,
    output sgtin_pkg::pipe_t   out_d
);
    import sgtin_pkg::*;

    logic  v_reg;
    pipe_t d_reg, d_next;

    always_comb
    begin
        d_next.kind   = kind;
        d_next.bad    = (prefix_length < LEN_MIN) || (prefix_length > LEN_MAX);
        d_next.part   = 3'(LEN_MAX - prefix_length);
        d_next.filter = filter_code;
        // drop digits above fourteen: input stays below twice the modulus
        d_next.rem    = (gtin_number >= GTIN_MOD) ? gtin_number - GTIN_MOD : gtin_number;
        d_next.pfx    = '0;
        d_next.itm    = '0;
        d_next.serial = serial_in;
        d_next.epc    = {epc_upper, epc_lower};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg <= d_next;
        end
    end

    assign out_v = v_reg;
    assign out_d = d_reg;
endmodule

// ===== rtl/sgtin_digit_stage.sv =====
module sgtin_digit_stage #(
    parameter int POS = 13
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_v,
    input  sgtin_pkg::pipe_t   in_d,
    output logic               out_v,
    output sgtin_pkg::pipe_t   out_d
);
    import sgtin_pkg::*;

    localparam logic [63:0] P   = pow10(POS);
    localparam int          IDX = POS - 1;

    logic        v_reg;
    pipe_t       d_reg, d_next;
    logic [3:0]  dig;

    always_comb
    begin
        dig = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (64'(in_d.rem) >= 64'(k) * P)
            begin
                dig = 4'(k);
            end
        end
        d_next     = in_d;
        d_next.rem = in_d.rem - REM_W'(64'(dig) * P);
        if (IDX == 12)
        begin
            // indicator digit leads the item reference
            d_next.itm = 24'(dig);
        end
        else if (IDX >= 32'(in_d.part))
        begin
            d_next.pfx = (in_d.pfx << 3) + (in_d.pfx << 1) + 40'(dig);
        end
        else
        begin
            d_next.itm = (in_d.itm << 3) + (in_d.itm << 1) + 24'(dig);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg <= d_next;
        end
    end

    assign out_v = v_reg;
    assign out_d = d_reg;
endmodule

// ===== verif/tb_sgtin96_encode_decode.sv =====
module tb_sgtin96_encode_decode;
    import sgtin_pkg::*;

    // Register indexes of the configuration port.
    localparam logic [0:0] REG_PREFIX_LEN = 1'b0;
    localparam logic [0:0] REG_FILTER     = 1'b1;
    // Item kinds.
    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_DECODE = 1'b1;
    // Block latency plus margin, used to drain before a register write.
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic        status;
        logic [31:0] tag_upper;
        logic [63:0] tag_lower;
        logic [2:0]  filter_out;
        logic [2:0]  partition_out;
        logic [39:0] prefix_out;
        logic [23:0] item_ref_out;
        logic [37:0] serial_out;
    } tag_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [3:0]  cfg_data;

    sgtin_item_if   item ();
    sgtin_result_if result ();

    sgtin96_encode_decode DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item.sink),
        .result    (result.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the configuration registers.
    logic [3:0]  cur_prefix_len;
    logic [2:0]  cur_filter;

    tag_result_t expected_tags[$];
    int          mismatches;
    int          idle_cycles;
    bit          hold_off_req;
    bit          timed_out;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Predict the result beat for one item under the current registers.
    function automatic tag_result_t predict_tag(logic kind, logic [46:0] gtin,
                                                logic [37:0] serial, logic [31:0] up,
                                                logic [63:0] lo);
        tag_result_t r;
        logic [63:0] g, ind, body, scale, pfx, itm;
        logic [57:0] hi;
        logic [2:0]  part;
        int          pbits;
        r = '0;
        if (kind == KIND_ENCODE)
        begin
            if (cur_prefix_len < 4'd6 || cur_prefix_len > 4'd12)
            begin
                r.status = 1'b1;
                return r;
            end
            part = 3'(4'd12 - cur_prefix_len);
            pbits = (part == 0) ? 40 : (part == 1) ? 37 : (part == 2) ? 34 :
                    (part == 3) ? 30 : (part == 4) ? 27 : (part == 5) ? 24 : 20;
            g = {17'd0, gtin} % 64'd100000000000000;
            ind = g / 64'd10000000000000;
            body = (g % 64'd10000000000000) / 64'd10;
            scale = 64'd1;
            for (int i = 0; i < part; i++)
            begin
                scale = scale * 64'd10;
            end
            pfx = body / scale;
            itm = ind * scale + body % scale;
            hi = {8'h30, cur_filter, part, 44'd0};
            hi = hi | 58'((pfx & ((64'd1 << pbits) - 64'd1)) << (44 - pbits))
                    | 58'(itm & ((64'd1 << (44 - pbits)) - 64'd1));
            r.tag_upper = hi[57:26];
            r.tag_lower = {hi[25:0], serial};
            return r;
        end
        hi = {up, lo[63:38]};
        part = hi[46:44];
        if (part == 3'd7)
        begin
            r.status = 1'b1;
            return r;
        end
        pbits = (part == 0) ? 40 : (part == 1) ? 37 : (part == 2) ? 34 :
                (part == 3) ? 30 : (part == 4) ? 27 : (part == 5) ? 24 : 20;
        r.filter_out    = hi[49:47];
        r.partition_out = part;
        r.prefix_out    = 40'((hi >> (44 - pbits)) & ((58'd1 << pbits) - 58'd1));
        r.item_ref_out  = 24'(hi & ((58'd1 << (44 - pbits)) - 58'd1));
        r.serial_out    = lo[37:0];
        return r;
    endfunction

    // Offer one beat after a random gap; record the prediction at acceptance.
    // Valid stays high after acceptance so the next beat can follow directly;
    // drop it only for a gap or a drain.
    task automatic send_item(logic kind, logic [46:0] gtin, logic [37:0] serial,
                             logic [31:0] up, logic [63:0] lo, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
        if (gap != 0)
        begin
            item.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.valid       <= 1'b1;
        item.kind        <= kind;
        item.gtin_number <= gtin;
        item.serial_in   <= serial;
        item.epc_upper   <= up;
        item.epc_lower   <= lo;
        @(posedge clk);
        while (!item.ready) @(posedge clk);
        expected_tags.push_back(predict_tag(kind, gtin, serial, up, lo));
    endtask

    // Stop offering, wait for every outstanding beat, then let the pipeline drain.
    task automatic drain_all();
        item.valid <= 1'b0;
        while (expected_tags.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [3:0] data);
        drain_all();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_PREFIX_LEN)
            cur_prefix_len = data;
        else
            cur_filter = data[2:0];
    endtask

    function automatic logic [46:0] rand_gtin();
        logic [63:0] v;
        v = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0)
            return v[46:0];
        return 47'(v % 64'd100000000000000);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_encode();
        send_item(KIND_ENCODE, rand_gtin(), 38'(rand64()), $urandom, rand64());
    endtask

    // A decode of a well-formed tag most of the time, raw bits otherwise.
    task automatic send_decode();
        logic [31:0] up;
        up = $urandom;
        if ($urandom_range(0, 4) != 0)
        begin
            up[31:24] = HEADER;
            up[20:18] = 3'($urandom_range(0, 6));
        end
        send_item(KIND_DECODE, rand_gtin(), 38'(rand64()), up, rand64());
    endtask

    task automatic test_directed();
        // extremes of the encode fields at reset settings
        send_item(KIND_ENCODE, 47'd0, 38'd0, 32'd0, 64'd0);
        send_item(KIND_ENCODE, 47'd99999999999999, '1, '1, '1);
        send_item(KIND_ENCODE, '1, '1, 32'd0, 64'd0);             // above 14 digits
        send_item(KIND_ENCODE, 47'd10614141000415, 38'd12345, '0, '0);
        // decode: partition 7, header ignored, raw values above decimal range
        send_item(KIND_DECODE, '1, '1, 32'h301C0000, 64'd0);
        send_item(KIND_DECODE, '0, '0, 32'd0, 64'd0);
        send_item(KIND_DECODE, '0, '0, '1, '1);
        send_item(KIND_DECODE, '0, '0, 32'hFFE3FFFF, '1);
        for (int p = 0; p < 7; p++)
            send_item(KIND_DECODE, '0, '0, {8'h30, 3'd5, 3'(p), 18'h3FFFF}, '1);
        // bad prefix lengths, then each edge of the valid range
        write_reg(REG_PREFIX_LEN, 4'd5);
        send_item(KIND_ENCODE, 47'd12345678901234, '1, '0, '0);
        write_reg(REG_PREFIX_LEN, 4'd13);
        send_item(KIND_ENCODE, 47'd12345678901234, '1, '0, '0);
        write_reg(REG_PREFIX_LEN, 4'd0);
        send_item(KIND_DECODE, '0, '0, 32'h30123456, '1);
        write_reg(REG_PREFIX_LEN, 4'd15);
        send_item(KIND_ENCODE, 47'd1, '0, '0, '0);
        write_reg(REG_FILTER, 4'd7);
        write_reg(REG_PREFIX_LEN, 4'd6);
        send_item(KIND_ENCODE, 47'd99999999999999, '1, '0, '0);
        write_reg(REG_PREFIX_LEN, 4'd12);
        send_item(KIND_ENCODE, 47'd99999999999999, '1, '0, '0);
        send_item(KIND_ENCODE, 47'd0, '0, '0, '0);
    endtask

    // Random phases over a spread of settings.
    task automatic test_random(int phases, int per_phase);
        for (int ph = 0; ph < phases; ph++)
        begin
            write_reg(REG_PREFIX_LEN, ($urandom_range(0, 7) == 0) ?
                      4'($urandom_range(0, 15)) : 4'($urandom_range(6, 12)));
            write_reg(REG_FILTER, 4'($urandom_range(0, 7)));
            for (int i = 0; i < per_phase; i++)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_encode();
                else
                    send_decode();
            end
        end
    endtask

    // Keep offering back to back while the receiver holds off.
    task automatic test_backpressure();
        hold_off_req = 1'b1;
        for (int i = 0; i < 60; i++)
            send_item(KIND_ENCODE, rand_gtin(), 38'(rand64()), '0, '0, 1);
        hold_off_req = 1'b0;
    endtask

    // Receiver ready: random waits per beat, plus one long hold-off.
    initial
    begin
        int wait_cycles;
        result.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                result.ready <= 1'b0;
                repeat (200) @(posedge clk);
                while (hold_off_req)
                begin
                    result.ready <= 1'b1;
                    @(posedge clk);
                end
            end
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (wait_cycles != 0)
            begin
                result.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            result.ready <= 1'b1;
            @(posedge clk);
            while (!(result.valid && result.ready)) @(posedge clk);
        end
    end

    // Compare each accepted result beat with the oldest prediction.
    always @(posedge clk)
    begin
        tag_result_t got, want;
        if (rst_n && result.valid && result.ready)
        begin
            got = {result.status, result.tag_upper, result.tag_lower, result.filter_out,
                   result.partition_out, result.prefix_out, result.item_ref_out,
                   result.serial_out};
            if (expected_tags.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", got);
            end
            else
            begin
                want = expected_tags.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    // Watchdog: count cycles in which no beat moves on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (item.valid && item.ready) || (result.valid && result.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_PREFIX_LEN;
        cfg_data       = 4'd0;
        item.valid       = 1'b0;
        item.kind        = KIND_ENCODE;
        item.gtin_number = '0;
        item.serial_in   = '0;
        item.epc_upper   = '0;
        item.epc_lower   = '0;
        cur_prefix_len = 4'd7;
        cur_filter     = 3'd0;
        hold_off_req   = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(14, 100);
        drain_all();
        if (mismatches == 0 && expected_tags.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
